// ===== sv/unsigned_number_formatter_unit_macros.svh =====
// Assertion macros shared by the number formatter modules.
// Depends on nothing; expects clk and arst_n in the including module.
`ifndef UNSIGNED_NUMBER_FORMATTER_UNIT_MACROS_SVH
`define UNSIGNED_NUMBER_FORMATTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define UFMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define UFMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ufmt_pkg.sv =====
// Package for the unsigned number formatter: ASCII constants, digit types,
// conversion result struct and the digit-to-character function. No dependencies.
`timescale 1ns / 1ps
package ufmt_pkg;
	localparam int VALUE_IN_W = 32;
	localparam int MAX_DIGITS = 10;
	localparam int DIGIT_W = 4;
	localparam logic [3:0] MAX_WIDTH = 4'd9;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] HEX_LETTER_BASE = 8'h37;

	typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digits_t;
	typedef logic [3:0] len_t;

	typedef struct packed {
		digits_t digits;
		len_t len;
	} conv_res_t;

	function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [7:0] d8;
		d8 = {4'd0, d};
		if (d > 4'd9) begin
			digit_char = d8 + HEX_LETTER_BASE;
		end else begin
			digit_char = d8 + ASCII_ZERO;
		end
	endfunction
endpackage

// ===== sv/ufmt_conv.sv =====
// Shift-and-correct converter: one value bit per cycle into ten BCD or hex digits,
// then a sizing state that finds the digit count. Depends on ufmt_pkg and the macro header.
`timescale 1ns / 1ps
`include "unsigned_number_formatter_unit_macros.svh"
module ufmt_conv #(
	parameter int VALUE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic dec,
	input logic [VALUE_BITS-1:0] value,
	output logic busy,
	output logic done,
	output ufmt_pkg::conv_res_t res
);
	import ufmt_pkg::*;

	localparam int CNT_W = $clog2(VALUE_BITS + 1);
	localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VALUE_BITS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_SIZE
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VALUE_BITS-1:0] val_q;
	digits_t digits_q;
	logic dec_q;
	logic ovf_q;
	logic done_q;
	conv_res_t res_q;

	digits_t corr;
	digits_t shifted;
	logic carry;
	len_t size_len;

	// add-3 correction in decimal mode, plain shift in hex mode
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (dec_q && (digits_q[i] >= 4'd5)) begin
				corr[i] = digits_q[i] + 4'd3;
			end else begin
				corr[i] = digits_q[i];
			end
		end
		{carry, shifted} = {corr, val_q[VALUE_BITS-1]};
	end

	// digit count: highest nonzero digit, at least one, ten on overflow
	always_comb begin
		size_len = 4'd1;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (digits_q[i] != '0) begin
				size_len = 4'(i + 1);
			end
		end
		if (ovf_q) begin
			size_len = 4'(MAX_DIGITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (load) begin
						cnt_q <= CNT_LOAD;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && load) begin
			val_q <= value;
			dec_q <= dec;
			digits_q <= '0;
			ovf_q <= 1'b0;
		end else if (state_q == ST_SHIFT) begin
			val_q <= {val_q[VALUE_BITS-2:0], 1'b0};
			digits_q <= shifted;
			ovf_q <= ovf_q | carry;
		end
		if (state_q == ST_SIZE) begin
			res_q.digits <= digits_q;
			res_q.len <= size_len;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res = res_q;

	`UFMT_ASSERT_NOW(a_load_idle, load, state_q == ST_IDLE, "load while converting")
	`UFMT_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "done held longer than one cycle")
	`UFMT_ASSERT_NOW(a_len_range, done_q, res_q.len >= 4'd1 && res_q.len <= 4'(MAX_DIGITS),
		"digit count out of range")
endmodule

// ===== sv/ufmt_emit.sv =====
// Character sequencer: pads then digits, most significant first, cut to room.
// Depends on ufmt_pkg and the macro header.
`timescale 1ns / 1ps
`include "unsigned_number_formatter_unit_macros.svh"
module ufmt_emit (
	input logic clk,
	input logic arst_n,
	input logic go,
	input ufmt_pkg::conv_res_t res,
	input logic [3:0] width,
	input logic [7:0] pad_char,
	input logic [3:0] room,
	output logic busy,
	output logic [7:0] character,
	output logic last,
	output logic strobe
);
	import ufmt_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic [3:0] pos_q;
	logic [3:0] rem_q;
	logic strobe_q;
	logic last_q;
	logic [7:0] char_q;

	logic [3:0] total;
	logic [3:0] count;

	assign total = (width > res.len) ? width : res.len;
	assign count = (room < total) ? room : total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			rem_q <= '0;
			strobe_q <= 1'b0;
			last_q <= 1'b0;
			char_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			last_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go && count != 4'd0) begin
						pos_q <= total - 4'd1;
						rem_q <= count;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					last_q <= (rem_q == 4'd1);
					if (pos_q >= res.len) begin
						char_q <= pad_char;
					end else begin
						char_q <= digit_char(res.digits[pos_q]);
					end
					pos_q <= pos_q - 4'd1;
					rem_q <= rem_q - 4'd1;
					if (rem_q == 4'd1) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = go || (state_q == ST_EMIT);
	assign character = char_q;
	assign last = last_q;
	assign strobe = strobe_q;

	`UFMT_ASSERT_NEXT(a_last_ends, strobe_q && last_q, !strobe_q, "transfer after last")
	`UFMT_ASSERT_NOW(a_go_idle, go, state_q == ST_IDLE, "new item while emitting")
	`UFMT_ASSERT_NOW(a_rem_live, state_q == ST_EMIT, rem_q != 4'd0, "emitting with nothing left")
endmodule

// ===== sv/unsigned_number_formatter_unit.sv =====
// Unsigned number formatter: prints one value per command as ASCII, decimal or
// upper-case hex, padded to a minimum width and cut to the room given. The
// value is converted one bit per cycle (through the shared shift-and-correct
// digit unit), a sizing state then finds the digit count, and then one
// character comes out per cycle on strobe, the final one with last set.
// The final character is on the ports in the cycle busy falls, and a new
// command can be accepted in that cycle. The receiver cannot stall, so every
// character must be taken in the cycle strobe is high. Room zero produces no
// transfer at all.
// Depends on ufmt_pkg, ufmt_conv and ufmt_emit.
`timescale 1ns / 1ps
module unsigned_number_formatter_unit #(
	parameter int VALUE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [31:0] value,
	input logic use_hex,
	input logic [3:0] min_width,
	input logic zero_pad,
	input logic [3:0] room,
	output logic [7:0] character,
	output logic last,
	output logic strobe
);
	import ufmt_pkg::*;

	logic accept;
	logic [VALUE_BITS-1:0] value_ext;
	logic [3:0] width_q;
	logic [7:0] pad_q;
	logic [3:0] room_q;
	logic conv_busy;
	logic conv_done;
	conv_res_t conv_res;
	logic emit_busy;

	assign accept = start && !busy;
	assign busy = conv_busy || emit_busy;

	if (VALUE_BITS > VALUE_IN_W) begin : g_widen
		assign value_ext = {{(VALUE_BITS - VALUE_IN_W){1'b0}}, value};
	end else if (VALUE_BITS == VALUE_IN_W) begin : g_same
		assign value_ext = value;
	end else begin : g_narrow
		assign value_ext = value[VALUE_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			width_q <= (min_width > MAX_WIDTH) ? MAX_WIDTH : min_width;
			pad_q <= zero_pad ? ASCII_ZERO : ASCII_SPACE;
			room_q <= room;
		end
	end

	ufmt_conv #(
		.VALUE_BITS(VALUE_BITS)
	) u_conv (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.dec(!use_hex),
		.value(value_ext),
		.busy(conv_busy),
		.done(conv_done),
		.res(conv_res)
	);

	ufmt_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.go(conv_done),
		.res(conv_res),
		.width(width_q),
		.pad_char(pad_q),
		.room(room_q),
		.busy(emit_busy),
		.character(character),
		.last(last),
		.strobe(strobe)
	);
endmodule
